// ===== src/lrp_pkg.sv =====
// lrp_pkg: types, codes and constants shared by the lr parser engine
// no dependencies
package lrp_pkg;

  localparam int TOKEN_W   = 8;
  localparam int STATE_W   = 7;
  localparam int COLUMN_W  = 5;
  localparam int RULE_W    = 7;
  localparam int ENTRY_W   = 11;
  localparam int LSYM_W    = 5;
  localparam int LEN_W     = 4;
  localparam int OP_W      = 3;
  localparam int KIND_W    = 3;
  localparam int VALUE_W   = 7;
  localparam int DEPTH_W   = 8;

  localparam int ENTRY_LIMIT = 100;
  localparam int ACCEPT_CODE = 999;

  localparam int DEF_STACK_DEPTH      = 128;
  localparam int DEF_NUM_STATES       = 128;
  localparam int DEF_NUM_NONTERMINALS = 32;
  localparam int DEF_NUM_RULES        = 128;
  localparam int DEF_MAX_REDUCES      = 63;

  typedef enum logic [OP_W-1:0] {
    OP_START  = 3'd0,
    OP_TOKEN  = 3'd1,
    OP_WR_ACT = 3'd2,
    OP_WR_GTO = 3'd3,
    OP_WR_RUL = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SHIFT  = 3'd0,
    KIND_REDUCE = 3'd1,
    KIND_ACCEPT = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_ACK    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_ACT,
    ST_RULE,
    ST_BASE,
    ST_GOTO
  } fsm_t;

endpackage

// ===== src/lrp_ram.sv =====
// lrp_ram: generic single-port-write, one-read ram with registered read
// no dependencies
module lrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lr_shift_reduce_parser.sv =====
// lr_shift_reduce_parser: table driven lr parser engine, top level
// depends on lrp_pkg and lrp_ram
//
// channel  | ports                                   | handshake
// request  | in_operation .. in_right_length         | start high and busy low
// result   | out_action_kind .. out_last             | out_valid, one cycle, no stall
//
// writes, start and ignored items: one result in the cycle after the request
// tokens: the first action follows the request through the stack top read, the
// action table read and the decode; each reduce adds a rule read, a stack read
// below the popped entries, a goto read and an action read of the new top
// all of it set by the registered reads of the stack and table memories
// reset clears control state only; memories hold garbage until written
// the receiver cannot stall; busy holds off the next request through the last result
module lr_shift_reduce_parser
  import lrp_pkg::*;
#(
  parameter int STACK_DEPTH      = DEF_STACK_DEPTH,
  parameter int NUM_STATES       = DEF_NUM_STATES,
  parameter int NUM_NONTERMINALS = DEF_NUM_NONTERMINALS,
  parameter int NUM_RULES        = DEF_NUM_RULES,
  parameter int MAX_REDUCES      = DEF_MAX_REDUCES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lrp_pkg::OP_W-1:0]    in_operation,
  input  logic [lrp_pkg::TOKEN_W-1:0] in_token,
  input  logic [lrp_pkg::STATE_W-1:0] in_state_index,
  input  logic [lrp_pkg::COLUMN_W-1:0] in_column_index,
  input  logic [lrp_pkg::RULE_W-1:0]  in_rule_index,
  input  logic signed [lrp_pkg::ENTRY_W-1:0] in_entry_value,
  input  logic [lrp_pkg::LSYM_W-1:0]  in_left_symbol,
  input  logic [lrp_pkg::LEN_W-1:0]   in_right_length,
  output logic                        out_valid,
  output logic [lrp_pkg::KIND_W-1:0]  out_action_kind,
  output logic [lrp_pkg::VALUE_W-1:0] out_action_value,
  output logic [lrp_pkg::DEPTH_W-1:0] out_stack_depth,
  output logic                        out_last
);

  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int SPW    = $clog2(STACK_DEPTH + 1);
  localparam int STW    = $clog2(NUM_STATES);
  localparam int NTW    = (NUM_NONTERMINALS > 1) ? $clog2(NUM_NONTERMINALS) : 1;
  localparam int RW     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int ACT_D  = NUM_STATES * (2 ** TOKEN_W);
  localparam int GTO_D  = NUM_STATES * (2 ** NTW);
  localparam int ACT_AW = $clog2(ACT_D);
  localparam int GTO_AW = $clog2(GTO_D);
  localparam int RCW    = 6;

  fsm_t state_r, state_nxt;

  logic [SPW-1:0]       sp_r;
  logic                 done_r;
  logic [TOKEN_W-1:0]   tok_r;
  logic [RCW-1:0]       red_r;
  logic [SPW-1:0]       base_r;
  logic [RULE_W-1:0]    rule_r;
  logic [LSYM_W-1:0]    lsym_r;
  logic [SPW-1:0]       sp_nxt;
  logic                 done_nxt;

  // result register
  logic                 ov_r, ov_nxt;
  kind_t                ok_r, ok_nxt;
  logic [VALUE_W-1:0]   oval_r, oval_nxt;
  logic                 olast_r, olast_nxt;

  // memory ports
  logic                 stk_we, act_we, gto_we, rul_we;
  logic [SAW-1:0]       stk_waddr, stk_raddr;
  logic [STATE_W-1:0]   stk_wdata, stk_rdata;
  logic [ACT_AW-1:0]    act_waddr, act_raddr;
  logic [ENTRY_W-1:0]   act_rdata;
  logic [GTO_AW-1:0]    gto_waddr, gto_raddr;
  logic [STATE_W:0]     gto_rdata;
  logic [RW-1:0]        rul_waddr, rul_raddr;
  logic [LSYM_W+LEN_W-1:0] rul_rdata;

  logic accept_req;
  assign accept_req = start && !busy;
  assign busy = (state_r != ST_IDLE) || ov_r;

  // goto entries carry a bad flag: negative or outside the state range
  logic gto_bad_in;
  assign gto_bad_in = in_entry_value[ENTRY_W-1] || (int'(in_entry_value) >= NUM_STATES);

  lrp_ram #(.WIDTH(STATE_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));
  lrp_ram #(.WIDTH(ENTRY_W), .DEPTH(ACT_D)) u_action (
    .clk, .we(act_we), .waddr(act_waddr), .wdata(in_entry_value),
    .raddr(act_raddr), .rdata(act_rdata));
  lrp_ram #(.WIDTH(STATE_W+1), .DEPTH(GTO_D)) u_goto (
    .clk, .we(gto_we), .waddr(gto_waddr),
    .wdata({gto_bad_in, in_entry_value[STATE_W-1:0]}),
    .raddr(gto_raddr), .rdata(gto_rdata));
  lrp_ram #(.WIDTH(LSYM_W+LEN_W), .DEPTH(2 ** RW)) u_rule (
    .clk, .we(rul_we), .waddr(rul_waddr), .wdata({in_left_symbol, in_right_length}),
    .raddr(rul_raddr), .rdata(rul_rdata));

  // decoded action entry
  logic signed [ENTRY_W-1:0] act_s;
  logic is_shift, is_reduce, is_accept;
  logic [ENTRY_W-1:0] neg_act;
  assign act_s     = signed'(act_rdata);
  assign neg_act   = ENTRY_W'(-act_s);
  assign is_shift  = (act_s >= 1) && (act_s <= ENTRY_LIMIT);
  assign is_reduce = (act_s <= -1) && (act_s >= -ENTRY_LIMIT);
  assign is_accept = (act_s == ACCEPT_CODE);

  logic [LSYM_W-1:0] r_lsym;
  logic [LEN_W-1:0]  r_len;
  assign {r_lsym, r_len} = rul_rdata;

  // write-address decode for load requests
  logic wr_act_ok, wr_gto_ok, wr_rul_ok;
  assign wr_act_ok = 32'(in_state_index) < NUM_STATES;
  assign wr_gto_ok = wr_act_ok && (32'(in_column_index) < NUM_NONTERMINALS);
  assign wr_rul_ok = 32'(in_rule_index) < NUM_RULES;

  logic [SPW+LEN_W:0] base_w;
  assign base_w = (SPW+LEN_W+1)'(sp_r) - (SPW+LEN_W+1)'(r_len);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_req && in_operation == OP_TOKEN && !done_r && sp_r != '0) begin
          state_nxt = ST_TOP;
        end
      end
      ST_TOP:  state_nxt = ST_ACT;
      ST_ACT: begin
        if (is_reduce && 32'(red_r) < MAX_REDUCES && 32'(neg_act) < NUM_RULES) begin
          state_nxt = ST_RULE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RULE: begin
        if (32'(r_lsym) < NUM_NONTERMINALS && (SPW+LEN_W+1)'(r_len) < (SPW+LEN_W+1)'(sp_r)
            && 32'(base_w) < STACK_DEPTH) begin
          state_nxt = ST_BASE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BASE: state_nxt = ST_GOTO;
      ST_GOTO: begin
        if (!gto_rdata[STATE_W]) begin
          state_nxt = ST_ACT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;
    act_we = 1'b0; act_waddr = '0; act_raddr = '0;
    gto_we = 1'b0; gto_waddr = '0; gto_raddr = '0;
    rul_we = 1'b0; rul_waddr = '0; rul_raddr = '0;
    sp_nxt = sp_r; done_nxt = done_r;
    ov_nxt = 1'b0; ok_nxt = KIND_ACK; oval_nxt = '0; olast_nxt = 1'b1;
    act_waddr = ACT_AW'(STW'(in_state_index) * (2 ** TOKEN_W) + in_token);
    gto_waddr = GTO_AW'(STW'(in_state_index) * (2 ** NTW) + NTW'(in_column_index));
    rul_waddr = RW'(in_rule_index);
    unique case (state_r)
      ST_IDLE: begin
        if (accept_req) begin
          priority case (1'b1)
            in_operation == OP_START: begin
              stk_we = 1'b1; stk_waddr = '0; stk_wdata = '0;
              sp_nxt = SPW'(1); done_nxt = 1'b0; ov_nxt = 1'b1;
            end
            in_operation == OP_TOKEN && !done_r && sp_r != '0: begin
              stk_raddr = SAW'(sp_r - SPW'(1));
            end
            in_operation == OP_WR_ACT: begin
              act_we = wr_act_ok; ov_nxt = 1'b1;
            end
            in_operation == OP_WR_GTO: begin
              gto_we = wr_gto_ok; ov_nxt = 1'b1;
            end
            in_operation == OP_WR_RUL: begin
              rul_we = wr_rul_ok; ov_nxt = 1'b1;
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      ST_TOP: begin
        act_raddr = ACT_AW'(STW'(stk_rdata) * (2 ** TOKEN_W) + tok_r);
      end
      ST_ACT: begin
        rul_raddr = RW'(neg_act);
        if (is_shift) begin
          ov_nxt = 1'b1;
          if (32'(act_s) < NUM_STATES && 32'(sp_r) < STACK_DEPTH) begin
            stk_we = 1'b1; stk_waddr = SAW'(sp_r); stk_wdata = STATE_W'(act_s);
            sp_nxt = sp_r + SPW'(1);
            ok_nxt = KIND_SHIFT; oval_nxt = VALUE_W'(act_s);
          end else begin
            ok_nxt = KIND_ERROR; done_nxt = 1'b1;
          end
        end else if (is_reduce && 32'(red_r) < MAX_REDUCES && 32'(neg_act) < NUM_RULES) begin
          ov_nxt = 1'b0;
        end else if (is_accept) begin
          ov_nxt = 1'b1; ok_nxt = KIND_ACCEPT; done_nxt = 1'b1;
        end else begin
          ov_nxt = 1'b1; ok_nxt = KIND_ERROR; done_nxt = 1'b1;
        end
      end
      ST_RULE: begin
        stk_raddr = SAW'(base_w - 1'b1);
        if (state_nxt == ST_IDLE) begin
          ov_nxt = 1'b1; ok_nxt = KIND_ERROR; done_nxt = 1'b1;
        end
      end
      ST_BASE: begin
        gto_raddr = GTO_AW'(STW'(stk_rdata) * (2 ** NTW) + NTW'(lsym_r));
      end
      ST_GOTO: begin
        ov_nxt = 1'b1;
        if (state_nxt == ST_ACT) begin
          // push the goto state and look up its action for the same token
          stk_we = 1'b1; stk_waddr = SAW'(base_r); stk_wdata = gto_rdata[STATE_W-1:0];
          sp_nxt = base_r + SPW'(1);
          ok_nxt = KIND_REDUCE; oval_nxt = rule_r; olast_nxt = 1'b0;
          act_raddr = ACT_AW'(STW'(gto_rdata[STATE_W-1:0]) * (2 ** TOKEN_W) + tok_r);
        end else begin
          ok_nxt = KIND_ERROR; done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sp_r    <= '0;
      done_r  <= 1'b1;
      ov_r    <= 1'b0;
      red_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      done_r  <= done_nxt;
      ov_r    <= ov_nxt;
      if (state_r == ST_IDLE) begin
        red_r <= '0;
      end else if (state_r == ST_GOTO) begin
        red_r <= red_r + RCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
    if (accept_req) tok_r <= in_token;
    if (state_r == ST_ACT) rule_r <= RULE_W'(neg_act);
    if (state_r == ST_RULE) begin
      lsym_r <= r_lsym;
      base_r <= SPW'(base_w);
    end
  end

  assign out_valid        = ov_r;
  assign out_action_kind  = ok_r;
  assign out_action_value = oval_r;
  assign out_stack_depth  = DEPTH_W'(sp_r);
  assign out_last         = olast_r;

  // no request taken while busy
  assert property (@(posedge clk) disable iff (!rst_n) busy |-> !accept_req)
    else $error("request accepted while busy");
  // a reduce result is never last, every other is
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_action_kind != KIND_REDUCE)))
    else $error("last flag mismatch");
  // stack depth never exceeds capacity
  assert property (@(posedge clk) disable iff (!rst_n) 32'(sp_r) <= STACK_DEPTH)
    else $error("stack overflow");
  // accept or error ends the parse
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action_kind == KIND_ERROR || out_action_kind == KIND_ACCEPT) |-> done_r)
    else $error("parse not ended");

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for the lr shift-reduce parser engine
// depends on lrp_pkg and lr_shift_reduce_parser; predicts every result in-line
// and checks them in order while the request side idles at random in some phases

module tb_top;
  import lrp_pkg::*;

  localparam int NSTATES     = DEF_NUM_STATES;
  localparam int NNTERM      = DEF_NUM_NONTERMINALS;
  localparam int NRULES      = DEF_NUM_RULES;
  localparam int SDEPTH      = DEF_STACK_DEPTH;
  localparam int MAXRED      = DEF_MAX_REDUCES;
  localparam int LIVE_ROWS   = 4;        // parser states the loaded grammar can reach
  localparam int LIVE_TOKENS = 4;        // token codes used by the random parses
  localparam int LIVE_NT     = 2;        // nonterminals produced by the live rules
  localparam int LIVE_RULES  = 6;        // rules 1 .. LIVE_RULES are reduced by live entries
  localparam int PHASE_ITEMS = 16;
  localparam int LIMIT       = 1000000;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic [TOKEN_W-1:0]        tok;
    logic [STATE_W-1:0]        row;
    logic [COLUMN_W-1:0]       col;
    logic [RULE_W-1:0]         rule;
    logic signed [ENTRY_W-1:0] val;
    logic [LSYM_W-1:0]         lsym;
    logic [LEN_W-1:0]          len;
  } req_t;

  typedef struct {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic [DEPTH_W-1:0]  depth;
    logic                last;
  } act_t;

  logic clk, rst_n, start, busy;
  logic [OP_W-1:0] in_operation;
  logic [TOKEN_W-1:0] in_token;
  logic [STATE_W-1:0] in_state_index;
  logic [COLUMN_W-1:0] in_column_index;
  logic [RULE_W-1:0] in_rule_index;
  logic signed [ENTRY_W-1:0] in_entry_value;
  logic [LSYM_W-1:0] in_left_symbol;
  logic [LEN_W-1:0] in_right_length;
  logic out_valid, out_last;
  logic [KIND_W-1:0] out_action_kind;
  logic [VALUE_W-1:0] out_action_value;
  logic [DEPTH_W-1:0] out_stack_depth;

  lr_shift_reduce_parser DUT (.*);

  // parser shadow state
  int act_tbl [NSTATES][256];
  int gto_shadow [NSTATES][NNTERM];
  int rule_lhs [NRULES];
  int rule_len [NRULES];
  int pstack [SDEPTH];
  int sp;
  bit done;

  req_t request_q[$];
  act_t action_q[$];
  int idle_pct;
  int mismatches;
  int cycles;
  req_t cur;

  function automatic void note_action(kind_t k, int v, bit l);
    act_t a;
    a.kind = k;
    a.value = v[VALUE_W-1:0];
    a.depth = sp[DEPTH_W-1:0];
    a.last = l;
    action_q.push_back(a);
  endfunction

  // run one token through the tables until shift, accept or error
  function automatic void parse_token(int tk);
    int top, a, r, ln, ls, base, g, nred;
    nred = 0;
    forever begin
      top = pstack[(sp - 1) % SDEPTH];
      a = act_tbl[top % NSTATES][tk];
      if (a >= 1 && a <= ENTRY_LIMIT) begin
        if (a >= NSTATES || sp >= SDEPTH) break;
        pstack[sp] = a;
        sp++;
        note_action(KIND_SHIFT, a, 1'b1);
        return;
      end else if (a <= -1 && a >= -ENTRY_LIMIT) begin
        r = -a;
        if (nred >= MAXRED || r >= NRULES) break;
        ln = rule_len[r];
        ls = rule_lhs[r];
        if (ls >= NNTERM || ln >= sp) break;
        base = sp - ln;
        if (base >= SDEPTH) break;
        g = gto_shadow[pstack[base - 1] % NSTATES][ls];
        if (g < 0 || g >= NSTATES) break;
        pstack[base] = g;
        sp = base + 1;
        note_action(KIND_REDUCE, r, 1'b0);
        nred++;
      end else if (a == ACCEPT_CODE) begin
        done = 1;
        note_action(KIND_ACCEPT, 0, 1'b1);
        return;
      end else begin
        break;
      end
    end
    done = 1;
    note_action(KIND_ERROR, 0, 1'b1);
  endfunction

  function automatic void predict_request(req_t q);
    case (q.op)
      OP_START: begin
        pstack[0] = 0;
        sp = 1;
        done = 0;
      end
      OP_TOKEN: begin
        if (!done && sp >= 1) begin
          parse_token(int'(q.tok));
          return;
        end
      end
      OP_WR_ACT: if (q.row < NSTATES) act_tbl[q.row][q.tok] = int'(q.val);
      OP_WR_GTO: if (q.row < NSTATES && q.col < NNTERM) gto_shadow[q.row][q.col] = int'(q.val);
      OP_WR_RUL: if (q.rule < NRULES) begin
        rule_lhs[q.rule] = q.lsym;
        rule_len[q.rule] = q.len;
      end
      default: ;
    endcase
    note_action(KIND_ACK, 0, 1'b1);
  endfunction

  // clock and reset
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
  end

  initial begin
    start = 0;
    in_operation = OP_START;
    in_token = '0;
    in_state_index = '0;
    in_column_index = '0;
    in_rule_index = '0;
    in_entry_value = '0;
    in_left_symbol = '0;
    in_right_length = '0;
    sp = 0;
    done = 1;
    mismatches = 0;
    cycles = 0;
    idle_pct = 0;
  end

  // request driver
  always @(posedge clk) begin
    bit taken;
    taken = start && !busy;
    if (taken) predict_request(cur);
    if (rst_n && (!start || taken)) begin
      if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur = request_q.pop_front();
        in_operation <= cur.op;
        in_token <= cur.tok;
        in_state_index <= cur.row;
        in_column_index <= cur.col;
        in_rule_index <= cur.rule;
        in_entry_value <= cur.val;
        in_left_symbol <= cur.lsym;
        in_right_length <= cur.len;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    act_t e;
    if (rst_n && out_valid) begin
      if (action_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d value=%0d depth=%0d last=%0d",
                   out_action_kind, out_action_value, out_stack_depth, out_last);
      end else begin
        e = action_q.pop_front();
        if (out_action_kind !== e.kind || out_action_value !== e.value ||
            out_stack_depth !== e.depth || out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp kind=%0d value=%0d depth=%0d last=%0d, got %0d %0d %0d %0d",
                     e.kind, e.value, e.depth, e.last, out_action_kind,
                     out_action_value, out_stack_depth, out_last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add(logic [OP_W-1:0] op, int tok = 0, int row = 0, int col = 0,
                     int rule = 0, int val = 0, int lsym = 0, int len = 0);
    req_t q;
    q.op = op;
    q.tok = tok;
    q.row = row;
    q.col = col;
    q.rule = rule;
    q.val = val;
    q.lsym = lsym;
    q.len = len;
    request_q.push_back(q);
  endtask

  // action entry that only ever leads to loaded states and rules
  function automatic int live_action();
    int p;
    p = $urandom_range(99);
    if (p < 35) return $urandom_range(LIVE_ROWS - 1, 1);
    if (p < 70) return -int'($urandom_range(LIVE_RULES, 1));
    if (p < 78) return ACCEPT_CODE;
    case ($urandom_range(3))
      0: return 0;
      1: return $urandom_range(ACCEPT_CODE - 1, ENTRY_LIMIT + 1);
      2: return $urandom_range(1023, ACCEPT_CODE + 1);
      default: return -int'($urandom_range(1024, ENTRY_LIMIT + 1));
    endcase
  endfunction

  function automatic int live_goto();
    if ($urandom_range(99) < 85) return $urandom_range(LIVE_ROWS - 1);
    if ($urandom_range(1)) return -int'($urandom_range(1024, 1));
    return $urandom_range(1023, NSTATES);
  endfunction

  function automatic int rule_length();
    if ($urandom_range(99) < 70) return $urandom_range(2);
    return $urandom_range(15);
  endfunction

  // table rewrites that keep every reachable entry loaded
  task automatic random_write();
    case ($urandom_range(5))
      0: add(OP_WR_ACT, $urandom_range(LIVE_TOKENS - 1), $urandom_range(LIVE_ROWS - 1),
             0, 0, live_action());
      1: add(OP_WR_ACT, $urandom_range(255), $urandom_range(NSTATES - 1, LIVE_ROWS), 0, 0,
             $urandom_range(2047) - 1024);
      2: add(OP_WR_GTO, 0, $urandom_range(LIVE_ROWS - 1), $urandom_range(LIVE_NT - 1), 0,
             live_goto());
      3: add(OP_WR_GTO, 0, $urandom_range(NSTATES - 1, LIVE_ROWS),
             $urandom_range(NNTERM - 1), 0, $urandom_range(2047) - 1024);
      4: add(OP_WR_RUL, 0, 0, 0, $urandom_range(LIVE_RULES, 1), 0,
             $urandom_range(LIVE_NT - 1), rule_length());
      default: add(OP_WR_RUL, 0, 0, 0, $urandom_range(NRULES - 1, ENTRY_LIMIT + 1), 0,
                   $urandom_range(NNTERM - 1), rule_length());
    endcase
  endtask

  task automatic drain();
    while (request_q.size() > 0 || start) @(posedge clk);
  endtask

  // stimulus and end of run
  initial begin
    int n, k, m;
    // tokens before any start and spare opcodes are only acknowledged
    add(OP_TOKEN, 255);
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) add(c[OP_W-1:0], 255, 127, 31, 127, -1, 31, 15);
    // extremes of the table rows, later overwritten or never read
    add(OP_WR_ACT, 255, 127, 0, 0, -1024);
    add(OP_WR_GTO, 0, 127, 31, 0, 1023);
    add(OP_WR_RUL, 0, 0, 0, 127, 0, 31, 15);

    // load every entry the live states can read with the live tokens
    for (int r = 0; r < LIVE_ROWS; r++)
      for (int t = 0; t < LIVE_TOKENS; t++) add(OP_WR_ACT, t, r, 0, 0, live_action());
    for (int r = 0; r < LIVE_ROWS; r++)
      for (int c = 0; c < LIVE_NT; c++) add(OP_WR_GTO, 0, r, c, 0, live_goto());
    for (int r = 1; r <= LIVE_RULES; r++)
      add(OP_WR_RUL, 0, 0, 0, r, 0, $urandom_range(LIVE_NT - 1), rule_length());

    // stack overflow: one token keeps shifting into state 1
    add(OP_WR_ACT, 255, 0, 0, 0, 1);
    add(OP_WR_ACT, 255, 1, 0, 0, 1);
    add(OP_START);
    repeat (SDEPTH) add(OP_TOKEN, 255);
    // reduce chain cap: empty rule whose goto comes back to the same state
    add(OP_WR_RUL, 0, 0, 0, 100, 0, 0, 0);
    add(OP_WR_GTO, 0, 2, 0, 0, 2);
    add(OP_WR_ACT, 254, 0, 0, 0, 2);
    add(OP_WR_ACT, 254, 2, 0, 0, -100);
    add(OP_START);
    add(OP_TOKEN, 254);
    add(OP_TOKEN, 254);
    // underflow: rule longer than the stack
    add(OP_WR_RUL, 0, 0, 0, 99, 0, 1, 15);
    add(OP_WR_ACT, 253, 0, 0, 0, 3);
    add(OP_WR_ACT, 253, 3, 0, 0, -99);
    add(OP_START);
    add(OP_TOKEN, 253);
    add(OP_TOKEN, 253);
    // bad goto after a pop
    add(OP_WR_RUL, 0, 0, 0, 98, 0, 1, 1);
    add(OP_WR_GTO, 0, 0, 1, 0, -5);
    add(OP_WR_ACT, 252, 3, 0, 0, -98);
    add(OP_WR_ACT, 252, 0, 0, 0, 3);
    add(OP_START);
    add(OP_TOKEN, 252);
    add(OP_TOKEN, 252);
    // accept, then a token that is ignored
    add(OP_WR_ACT, 251, 0, 0, 0, ACCEPT_CODE);
    add(OP_START);
    add(OP_TOKEN, 251);
    add(OP_TOKEN, 0);
    drain();

    // random phases: mostly parses, some table rewrites and noise
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        k = $urandom_range(99);
        if (k < 70) begin
          m = $urandom_range(5, 2);
          add(OP_START);
          repeat (m) add(OP_TOKEN, $urandom_range(LIVE_TOKENS - 1));
          n += m + 1;
        end else if (k < 90) begin
          random_write();
          n++;
        end else if (k < 95) begin
          add(OP_TOKEN, $urandom_range(LIVE_TOKENS - 1));
          n++;
        end else begin
          add(OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), $urandom_range(255),
              $urandom_range(127), $urandom_range(31), $urandom_range(127),
              $urandom_range(2047) - 1024, $urandom_range(31), $urandom_range(15));
          n++;
        end
      end
      drain();
    end

    while (action_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && action_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== lr_shift_reduce_parser.f =====
src/lrp_pkg.sv
src/lrp_ram.sv
src/lr_shift_reduce_parser.sv
sim/tb_top.sv
